// ----- rtl/boel_pkg.sv -----
// Shared types and codes for the bounded ordered list engine.
`default_nettype none

package boel_pkg;

    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_BACK  = 3'd1,
        OP_DELETE    = 3'd2,
        OP_READ_FWD  = 3'd3,
        OP_READ_BWD  = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    // Command broadcast to every cell of the chain.
    typedef enum logic [2:0] {
        CMD_HOLD      = 3'd0,
        CMD_MATCH     = 3'd1,
        CMD_INS_FRONT = 3'd2,
        CMD_INS_BACK  = 3'd3,
        CMD_DELETE    = 3'd4,
        CMD_ROT_FWD   = 3'd5,
        CMD_ROT_BWD   = 3'd6
    } cmd_t;

    typedef struct packed {
        cmd_t              cmd;
        logic [DATA_W-1:0] value;
    } cell_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/boel_cell.sv -----
// One list cell: holds one entry and its match flag, trades data with neighbors.
`default_nettype none

module boel_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 5
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  boel_pkg::cell_cmd_t         cmd,
    input  logic [CNT_W-1:0]            count,
    input  logic [boel_pkg::DATA_W-1:0] left_data,
    input  logic [boel_pkg::DATA_W-1:0] right_data,
    input  logic [boel_pkg::DATA_W-1:0] head_data,
    input  logic                        hit_in,
    output logic                        hit_out,
    output logic [boel_pkg::DATA_W-1:0] data,
    output logic [boel_pkg::DATA_W-1:0] tail_data
);

    logic [boel_pkg::DATA_W-1:0] data_reg;
    logic [boel_pkg::DATA_W-1:0] data_next;
    logic                        match_reg;
    logic                        match_next;
    logic                        live;
    logic                        is_tail;
    logic                        is_slot;

    assign live    = CNT_W'(INDEX) < count;
    assign is_tail = CNT_W'(INDEX + 1) == count;
    assign is_slot = CNT_W'(INDEX) == count;

    // Prefix of hits: this cell and all cells after the first match move.
    assign hit_out   = hit_in | (match_reg & live);
    assign data      = data_reg;
    assign tail_data = is_tail ? data_reg : '0;

    always_comb
    begin
        data_next  = data_reg;
        match_next = match_reg;
        case (cmd.cmd)
            boel_pkg::CMD_MATCH:     match_next = (data_reg == cmd.value);
            boel_pkg::CMD_INS_FRONT: data_next  = left_data;
            boel_pkg::CMD_INS_BACK:
            begin
                if (is_slot)
                begin
                    data_next = cmd.value;
                end
            end
            boel_pkg::CMD_DELETE:
            begin
                if (hit_out)
                begin
                    data_next = right_data;
                end
            end
            boel_pkg::CMD_ROT_FWD:   data_next = is_tail ? head_data : right_data;
            boel_pkg::CMD_ROT_BWD:   data_next = left_data;
            default:                 data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

`default_nettype wire

// ----- rtl/bounded_ordered_list_engine_unit.sv -----
// Top level of the bounded ordered list engine: sequencer, count and result register.
`default_nettype none

// The list lives in a chain of LIST_DEPTH cells, front at cell 0, each cell
// holding one signed 32-bit entry. One request is worked at a time. An insert
// or a delete has an accept cycle, in which every cell compares its entry
// against the request value, then a step in which the chain shifts and the
// single status beat is loaded, once the result register is free. A read of
// N entries rotates the chain by one cell per cycle while the result register
// is free, streaming the front cell (forward) or the tail cell (backward) into
// the result register, and after N rotations it is back in its original order.
// A read of an empty list gives one beat with status empty. An insert into a
// full list is refused with status full, a delete with no match reports not
// found. An op code above 4 is dropped with no beat. The result register lets
// a new request be accepted while the previous beat waits; a stalled rsp_ready
// holds the chain until the beat is taken.
module bounded_ordered_list_engine_unit #(
    parameter int LIST_DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  logic [2:0]         op,
    input  logic signed [31:0] value,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output logic signed [31:0] item_value,
    output logic [1:0]         status,
    output logic               last
);

    localparam int CNT_W = $clog2(LIST_DEPTH + 1);

    boel_pkg::state_t            state_reg;
    boel_pkg::state_t            state_next;
    logic [2:0]                  op_reg;
    logic [boel_pkg::DATA_W-1:0] value_reg;
    logic [CNT_W-1:0]            count_reg;
    logic [CNT_W-1:0]            count_next;
    logic [CNT_W-1:0]            remain_reg;
    logic [CNT_W-1:0]            remain_next;

    logic                        rsp_valid_reg;
    logic [boel_pkg::DATA_W-1:0] item_value_reg;
    boel_pkg::status_t           status_reg;
    logic                        last_reg;

    logic                        accept;
    logic                        out_free;
    logic                        load;
    logic [boel_pkg::DATA_W-1:0] ld_value;
    boel_pkg::status_t           ld_status;
    logic                        ld_last;
    logic                        exec_done;

    boel_pkg::cell_cmd_t         cell_cmd;
    logic [boel_pkg::DATA_W-1:0] cell_data [LIST_DEPTH];
    logic [boel_pkg::DATA_W-1:0] tail_part [LIST_DEPTH];
    logic                        hit       [LIST_DEPTH+1];
    logic [boel_pkg::DATA_W-1:0] head_data;
    logic [boel_pkg::DATA_W-1:0] tail_data;
    logic [boel_pkg::DATA_W-1:0] front_in;
    logic                        found;

    assign accept   = req_valid && req_ready;
    assign out_free = !rsp_valid_reg || rsp_ready;

    assign head_data = cell_data[0];
    assign found     = hit[LIST_DEPTH];
    assign hit[0]    = 1'b0;

    // Cell 0 takes the new value on insert front and the wrapped tail on backward read.
    assign front_in = (cell_cmd.cmd == boel_pkg::CMD_ROT_BWD) ? tail_data : value_reg;

    // Select the tail entry: only the tail cell drives a nonzero part.
    always_comb
    begin
        tail_data = '0;
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            tail_data = tail_data | tail_part[i];
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            boel_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = boel_pkg::S_EXEC;
                end
            end
            boel_pkg::S_EXEC:
            begin
                if (exec_done)
                begin
                    state_next = boel_pkg::S_IDLE;
                end
            end
            default: state_next = boel_pkg::S_IDLE;
        endcase
    end

    // Sequencer outputs: chain command, count update, result beat.
    always_comb
    begin
        req_ready      = 1'b0;
        cell_cmd.cmd   = boel_pkg::CMD_HOLD;
        cell_cmd.value = value_reg;
        count_next     = count_reg;
        remain_next    = remain_reg;
        load           = 1'b0;
        ld_value       = '0;
        ld_status      = boel_pkg::ST_OK;
        ld_last        = 1'b1;
        exec_done      = 1'b0;
        case (state_reg)
            boel_pkg::S_IDLE:
            begin
                req_ready      = 1'b1;
                cell_cmd.value = value;
                remain_next    = count_reg;
                if (req_valid)
                begin
                    // Capture per-cell match flags for a possible delete.
                    cell_cmd.cmd = boel_pkg::CMD_MATCH;
                end
            end
            boel_pkg::S_EXEC:
            begin
                case (op_reg)
                    boel_pkg::OP_INS_FRONT, boel_pkg::OP_INS_BACK:
                    begin
                        if (out_free)
                        begin
                            load      = 1'b1;
                            exec_done = 1'b1;
                            if (count_reg == CNT_W'(LIST_DEPTH))
                            begin
                                ld_status = boel_pkg::ST_FULL;
                            end
                            else
                            begin
                                cell_cmd.cmd = (op_reg == boel_pkg::OP_INS_FRONT) ?
                                               boel_pkg::CMD_INS_FRONT :
                                               boel_pkg::CMD_INS_BACK;
                                count_next   = count_reg + 1'b1;
                            end
                        end
                    end
                    boel_pkg::OP_DELETE:
                    begin
                        if (out_free)
                        begin
                            load      = 1'b1;
                            exec_done = 1'b1;
                            if (count_reg == '0)
                            begin
                                ld_status = boel_pkg::ST_EMPTY;
                            end
                            else if (!found)
                            begin
                                ld_status = boel_pkg::ST_NOT_FOUND;
                            end
                            else
                            begin
                                cell_cmd.cmd = boel_pkg::CMD_DELETE;
                                count_next   = count_reg - 1'b1;
                            end
                        end
                    end
                    boel_pkg::OP_READ_FWD, boel_pkg::OP_READ_BWD:
                    begin
                        if (out_free)
                        begin
                            load = 1'b1;
                            if (count_reg == '0)
                            begin
                                ld_status = boel_pkg::ST_EMPTY;
                                exec_done = 1'b1;
                            end
                            else
                            begin
                                // Stream one entry and rotate the chain by one cell.
                                if (op_reg == boel_pkg::OP_READ_FWD)
                                begin
                                    cell_cmd.cmd = boel_pkg::CMD_ROT_FWD;
                                    ld_value     = head_data;
                                end
                                else
                                begin
                                    cell_cmd.cmd = boel_pkg::CMD_ROT_BWD;
                                    ld_value     = tail_data;
                                end
                                ld_last     = (remain_reg == CNT_W'(1));
                                exec_done   = ld_last;
                                remain_next = remain_reg - 1'b1;
                            end
                        end
                    end
                    default: exec_done = 1'b1;
                endcase
            end
            default: req_ready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= boel_pkg::S_IDLE;
            count_reg     <= '0;
            remain_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            remain_reg <= remain_next;
            if (load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Request and result payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= op;
            value_reg <= value;
        end
        if (load)
        begin
            item_value_reg <= ld_value;
            status_reg     <= ld_status;
            last_reg       <= ld_last;
        end
    end

    generate
        for (genvar i = 0; i < LIST_DEPTH; i++)
        begin : g_cell
            logic [boel_pkg::DATA_W-1:0] left_data;
            logic [boel_pkg::DATA_W-1:0] right_data;

            if (i == 0)
            begin : g_first
                assign left_data = front_in;
            end
            else
            begin : g_mid_l
                assign left_data = cell_data[i-1];
            end

            if (i == LIST_DEPTH - 1)
            begin : g_end
                assign right_data = cell_data[i];
            end
            else
            begin : g_mid_r
                assign right_data = cell_data[i+1];
            end

            boel_cell #(
                .INDEX (i),
                .CNT_W (CNT_W)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cmd        (cell_cmd),
                .count      (count_reg),
                .left_data  (left_data),
                .right_data (right_data),
                .head_data  (head_data),
                .hit_in     (hit[i]),
                .hit_out    (hit[i+1]),
                .data       (cell_data[i]),
                .tail_data  (tail_part[i])
            );
        end
    endgenerate

    assign rsp_valid  = rsp_valid_reg;
    assign item_value = item_value_reg;
    assign status     = status_reg;
    assign last       = last_reg;

endmodule

`default_nettype wire

// ----- rtl/boel_checker.sv -----
// Port-level checker for the list engine and its bind to the top level.
`default_nettype none

module boel_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_ready,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input logic signed [31:0] item_value,
    input logic [1:0]         status,
    input logic               last
);

    // Hold a stalled beat.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(item_value) &&
        $stable(status) && $stable(last))
        else $error("stalled result beat changed");

    // Status-only beats end their request and carry no entry.
    a_status_only: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status != boel_pkg::ST_OK) |-> last && (item_value == 32'sd0))
        else $error("error status beat not final or carries data");

    // Mid-stream read beats are always ok.
    a_stream_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !last |-> status == boel_pkg::ST_OK)
        else $error("non-final beat with error status");

    // One request in work at a time: no accept right after an accept.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while previous one in work");

endmodule

bind bounded_ordered_list_engine_unit boel_checker u_boel_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .item_value (item_value),
    .status     (status),
    .last       (last)
);

`default_nettype wire
